[rtl/core/biquad_cascade_iir_filter_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the biquad cascade filter
// Clocked property checks with a synchronous active-low reset as disable.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/biq_pkg.sv]
// ---------------------------------------------------------------------------
// biq_pkg
// Types, formats and coefficient slot codes of the biquad cascade filter.
// ---------------------------------------------------------------------------
package biq_pkg;

    // Default cascade makeup
    localparam int LOWPASS_SECTIONS_DEF  = 2;
    localparam int HIGHPASS_SECTIONS_DEF = 2;
    localparam int NOTCH_SECTIONS_DEF    = 2;

    localparam int SAMPLE_W = 24;   // Q1.23
    localparam int COEFF_W  = 24;   // Q3.21
    localparam int DELAY_W  = 32;   // Q9.23
    localparam int PROD_W   = COEFF_W + DELAY_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_SHIFT = 21;
    localparam int SHIFT_W  = ACC_W - FRAC_SHIFT;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEFF_W-1:0]  t_coeff;
    typedef logic signed [DELAY_W-1:0]  t_delay;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic        [2:0]          t_slot;

    // Half an output LSB, added before the right shift
    localparam t_acc ROUND_HALF = t_acc'(1) <<< (FRAC_SHIFT - 1);

    // Commands
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Coefficient slots within one section
    localparam t_slot SLOT_SCALE = 3'd0;
    localparam t_slot SLOT_B0    = 3'd1;
    localparam t_slot SLOT_B1    = 3'd2;
    localparam t_slot SLOT_B2    = 3'd3;
    localparam t_slot SLOT_A1    = 3'd4;
    localparam t_slot SLOT_A2    = 3'd5;
    localparam int    SLOT_COUNT = 6;

    // Map the load item's slot field onto a storage slot; slot A1 with the
    // high bit set names A2.
    function automatic t_slot f_slot_index(input t_slot slot, input logic slot_hi);
        t_slot k;
        k = slot;
        if (slot == SLOT_A1 && slot_hi) begin
            k = SLOT_A2;
        end
        return k;
    endfunction

endpackage

[rtl/core/biquad_cascade_iir_filter.sv]
// ---------------------------------------------------------------------------
// biquad_cascade_iir_filter
// Cascade of direct-form-II biquads (low-pass, high-pass, notch) sharing one
// multiplier; coefficients and delay words live in on-chip memories.
// ---------------------------------------------------------------------------
// Sequencing: a filter run walks each section in eight steps on the single shared
//   multiplier, and no new item is taken until its result has moved into the
//   output register; load items write the coefficient memory as they transfer.
// Reset: synchronous, active low; clears control and the per-entry valid bits,
//   so every coefficient and delay word reads as zero until written.
`include "biquad_cascade_iir_filter_macros.svh"

module biquad_cascade_iir_filter #(
    parameter int LOWPASS_SECTIONS  = biq_pkg::LOWPASS_SECTIONS_DEF,
    parameter int HIGHPASS_SECTIONS = biq_pkg::HIGHPASS_SECTIONS_DEF,
    parameter int NOTCH_SECTIONS    = biq_pkg::NOTCH_SECTIONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  biq_pkg::t_sample      i_sample_in,
    input  logic [2:0]            i_coeff_section,
    input  biq_pkg::t_slot        i_coeff_slot,
    input  logic                  i_coeff_slot_hi,
    input  biq_pkg::t_coeff       i_coeff_value,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output biq_pkg::t_sample      o_sample_out,
    output logic                  o_saturated
);

    // -----------------------------------------------------------------------
    // Sizing
    // -----------------------------------------------------------------------
    localparam int TOTAL     = LOWPASS_SECTIONS + HIGHPASS_SECTIONS + NOTCH_SECTIONS;
    localparam int CF_DEPTH  = ((TOTAL < 1) ? 1 : TOTAL) * biq_pkg::SLOT_COUNT;
    localparam int CF_AW     = $clog2(CF_DEPTH);
    localparam int CF_WAW    = CF_AW + 3;
    localparam int DLY_DEPTH = (TOTAL < 2) ? 2 : TOTAL;
    localparam int SEC_W     = $clog2(DLY_DEPTH);
    localparam int DLY_MW    = 2 * biq_pkg::DELAY_W;

    // Controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Steps of one section; all but FB2 and FF2 issue the next one's coefficient read
    localparam logic [3:0] STEP_PRE = 4'd1;  // load delays, scale*x
    localparam logic [3:0] STEP_FB1 = 4'd2;  // acc = half + scale*x, a1*w1
    localparam logic [3:0] STEP_FB2 = 4'd3;  // acc -= a1*w1, a2*w2
    localparam logic [3:0] STEP_W0  = 4'd4;  // w0 = sat(acc - a2*w2)
    localparam logic [3:0] STEP_FF0 = 4'd5;  // b0*w0
    localparam logic [3:0] STEP_FF1 = 4'd6;  // acc = half + b0*w0, b1*w1
    localparam logic [3:0] STEP_FF2 = 4'd7;  // acc += b1*w1, b2*w2
    localparam logic [3:0] STEP_Y   = 4'd8;  // y = sat(acc + b2*w2), write delays

    // -----------------------------------------------------------------------
    // Control registers
    // -----------------------------------------------------------------------
    logic [1:0]             r_state, n_state;
    logic [3:0]             r_step, n_step;
    logic [SEC_W-1:0]       r_sec, n_sec;
    logic [CF_AW-1:0]       r_cf_base, n_cf_base;
    logic                   r_out_vld, n_out_vld;
    logic [CF_DEPTH-1:0]    r_cf_vld;
    logic [DLY_DEPTH-1:0]   r_dly_vld;

    // Memories and their registered read ports
    biq_pkg::t_coeff        coeff_mem [CF_DEPTH];
    logic [DLY_MW-1:0]      dly_mem [DLY_DEPTH];
    biq_pkg::t_coeff        r_cf_q;
    logic                   r_cf_vq;
    logic [DLY_MW-1:0]      r_dly_q;
    logic                   r_dly_vq;

    // Datapath registers
    biq_pkg::t_sample       r_x;
    biq_pkg::t_delay        r_w0, r_w1, r_w2;
    biq_pkg::t_prod         r_prod;
    biq_pkg::t_acc          r_acc;
    logic                   r_flag;
    biq_pkg::t_sample       r_out_sample;
    logic                   r_out_sat;

    // Combinational
    logic                   w_in_fire;
    logic                   w_filter_go;
    logic                   w_last_sec;
    logic                   w_out_load;
    logic [CF_AW-1:0]       w_cf_ra;
    logic [SEC_W-1:0]       w_dly_ra;
    logic                   w_cf_we;
    biq_pkg::t_slot         w_cf_wk;
    logic [CF_WAW-1:0]      w_cf_wa_full;
    logic [CF_AW-1:0]       w_cf_wa;
    logic                   w_dly_we;
    biq_pkg::t_coeff        w_coef;
    biq_pkg::t_delay        w_mul_b;
    biq_pkg::t_prod         w_prod;
    biq_pkg::t_acc          w_add_a;
    biq_pkg::t_acc          w_prod_x;
    biq_pkg::t_acc          w_sum;
    logic                   w_sub;
    logic [biq_pkg::SHIFT_W-1:0] w_shift;
    logic                   w_ovf_w0;
    logic                   w_ovf_y;
    biq_pkg::t_delay        w_w0_sat;
    biq_pkg::t_sample       w_y_sat;

    // -----------------------------------------------------------------------
    // Handshake
    // -----------------------------------------------------------------------
    // Take a new item only between filter runs; the output register lets the
    // next item start while the last result still waits downstream.
    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_filter_go  = w_in_fire && (i_command == biq_pkg::CMD_FILTER);
    assign w_last_sec   = (r_sec == SEC_W'(TOTAL - 1));
    assign w_out_load   = (r_state == ST_FIN) && (!r_out_vld || i_out_ready);

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_sample;
    assign o_saturated  = r_out_sat;

    // -----------------------------------------------------------------------
    // Sequencer: walk every section in eight steps
    // -----------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_sec     = r_sec;
        n_cf_base = r_cf_base;
        case (r_state)
            ST_IDLE: begin
                if (w_filter_go) begin
                    n_sec     = '0;
                    n_cf_base = '0;
                    n_step    = STEP_PRE;
                    // an empty cascade passes the sample straight through
                    n_state   = (TOTAL == 0) ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == STEP_Y) begin
                    if (w_last_sec) begin
                        n_state = ST_FIN;
                    end else begin
                        n_sec     = r_sec + SEC_W'(1);
                        n_cf_base = r_cf_base + CF_AW'(biq_pkg::SLOT_COUNT);
                        n_step    = STEP_PRE;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the downstream side takes it
    always_comb begin
        if (w_out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // -----------------------------------------------------------------------
    // Memory addressing
    // -----------------------------------------------------------------------
    // The coefficient read issued in one step is consumed in the next one.
    always_comb begin
        w_cf_ra  = r_cf_base;
        w_dly_ra = r_sec;
        case (r_state)
            ST_IDLE: begin
                w_cf_ra  = CF_AW'(biq_pkg::SLOT_SCALE);
                w_dly_ra = '0;
            end
            ST_RUN: begin
                case (r_step)
                    STEP_PRE: w_cf_ra = r_cf_base + CF_AW'(biq_pkg::SLOT_A1);
                    STEP_FB1: w_cf_ra = r_cf_base + CF_AW'(biq_pkg::SLOT_A2);
                    STEP_W0:  w_cf_ra = r_cf_base + CF_AW'(biq_pkg::SLOT_B0);
                    STEP_FF0: w_cf_ra = r_cf_base + CF_AW'(biq_pkg::SLOT_B1);
                    STEP_FF1: w_cf_ra = r_cf_base + CF_AW'(biq_pkg::SLOT_B2);
                    STEP_Y: begin
                        // prefetch scale and delays of the next section
                        w_cf_ra = r_cf_base + CF_AW'(biq_pkg::SLOT_COUNT)
                                  + CF_AW'(biq_pkg::SLOT_SCALE);
                        if (!w_last_sec) begin
                            w_dly_ra = r_sec + SEC_W'(1);
                        end
                    end
                    default: w_cf_ra = r_cf_base;
                endcase
            end
            default: begin
                w_cf_ra  = r_cf_base;
                w_dly_ra = r_sec;
            end
        endcase
    end

    // Coefficient load: drop writes to unknown slots or absent sections
    assign w_cf_wk      = biq_pkg::f_slot_index(i_coeff_slot, i_coeff_slot_hi);
    assign w_cf_wa_full = CF_WAW'(i_coeff_section) * CF_WAW'(biq_pkg::SLOT_COUNT)
                          + CF_WAW'(w_cf_wk);
    assign w_cf_wa      = w_cf_wa_full[CF_AW-1:0];

    always_comb begin
        w_cf_we = w_in_fire && (i_command == biq_pkg::CMD_LOAD)
                  && (32'(i_coeff_section) < TOTAL)
                  && (i_coeff_slot inside {[biq_pkg::SLOT_SCALE:biq_pkg::SLOT_A1]});
    end

    assign w_dly_we = (r_state == ST_RUN) && (r_step == STEP_Y);

    // -----------------------------------------------------------------------
    // Shared multiply-accumulate
    // -----------------------------------------------------------------------
    // Entries never written read as zero.
    assign w_coef = r_cf_vq ? r_cf_q : '0;

    always_comb begin
        case (r_step)
            STEP_PRE: w_mul_b = {{(biq_pkg::DELAY_W - biq_pkg::SAMPLE_W){r_x[23]}}, r_x};
            STEP_FB1: w_mul_b = r_w1;
            STEP_FB2: w_mul_b = r_w2;
            STEP_FF0: w_mul_b = r_w0;
            STEP_FF1: w_mul_b = r_w1;
            STEP_FF2: w_mul_b = r_w2;
            default:  w_mul_b = r_w0;
        endcase
    end

    assign w_prod = w_coef * w_mul_b;

    // One adder: start a sum from the rounding half, subtract feedback terms
    assign w_add_a  = ((r_step == STEP_FB1) || (r_step == STEP_FF1))
                      ? biq_pkg::ROUND_HALF : r_acc;
    assign w_sub    = (r_step == STEP_FB2) || (r_step == STEP_W0);
    assign w_prod_x = {{(biq_pkg::ACC_W - biq_pkg::PROD_W){r_prod[biq_pkg::PROD_W-1]}},
                       r_prod};
    assign w_sum    = w_sub ? (w_add_a - w_prod_x) : (w_add_a + w_prod_x);
    assign w_shift  = w_sum[biq_pkg::ACC_W-1:biq_pkg::FRAC_SHIFT];

    // Saturate: overflow when the dropped top bits disagree with the sign
    assign w_ovf_w0 = !((&w_shift[biq_pkg::SHIFT_W-1:biq_pkg::DELAY_W-1])
                      || !(|w_shift[biq_pkg::SHIFT_W-1:biq_pkg::DELAY_W-1]));
    assign w_ovf_y  = !((&w_shift[biq_pkg::SHIFT_W-1:biq_pkg::SAMPLE_W-1])
                      || !(|w_shift[biq_pkg::SHIFT_W-1:biq_pkg::SAMPLE_W-1]));

    always_comb begin
        if (w_ovf_w0) begin
            w_w0_sat = w_shift[biq_pkg::SHIFT_W-1]
                       ? {1'b1, {(biq_pkg::DELAY_W-1){1'b0}}}
                       : {1'b0, {(biq_pkg::DELAY_W-1){1'b1}}};
        end else begin
            w_w0_sat = w_shift[biq_pkg::DELAY_W-1:0];
        end
        if (w_ovf_y) begin
            w_y_sat = w_shift[biq_pkg::SHIFT_W-1]
                      ? {1'b1, {(biq_pkg::SAMPLE_W-1){1'b0}}}
                      : {1'b0, {(biq_pkg::SAMPLE_W-1){1'b1}}};
        end else begin
            w_y_sat = w_shift[biq_pkg::SAMPLE_W-1:0];
        end
    end

    // -----------------------------------------------------------------------
    // Control state and valid bits
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= STEP_PRE;
            r_sec     <= '0;
            r_cf_base <= '0;
            r_out_vld <= 1'b0;
            r_cf_vld  <= '0;
            r_dly_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_sec     <= n_sec;
            r_cf_base <= n_cf_base;
            r_out_vld <= n_out_vld;
            if (w_cf_we) begin
                r_cf_vld[w_cf_wa] <= 1'b1;
            end
            if (w_dly_we) begin
                r_dly_vld[r_sec] <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_cf_we) begin
            coeff_mem[w_cf_wa] <= i_coeff_value;
        end
        r_cf_q  <= coeff_mem[w_cf_ra];
        r_cf_vq <= r_cf_vld[w_cf_ra];
    end

    // Delay word pair {w1, w2}; the prefetch never needs the entry being written
    always_ff @(posedge i_clk) begin
        if (w_dly_we) begin
            dly_mem[r_sec] <= {r_w0, r_w1};
        end
        r_dly_q  <= dly_mem[w_dly_ra];
        r_dly_vq <= r_dly_vld[w_dly_ra];
    end

    // -----------------------------------------------------------------------
    // Datapath registers
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;

        if (w_filter_go) begin
            r_x    <= i_sample_in;
            r_flag <= 1'b0;
        end

        if (r_state == ST_RUN) begin
            case (r_step)
                STEP_PRE: begin
                    r_w1 <= r_dly_vq ? r_dly_q[DLY_MW-1:biq_pkg::DELAY_W] : '0;
                    r_w2 <= r_dly_vq ? r_dly_q[biq_pkg::DELAY_W-1:0] : '0;
                end
                STEP_FB1, STEP_FB2, STEP_FF1, STEP_FF2: begin
                    r_acc <= w_sum;
                end
                STEP_W0: begin
                    r_w0   <= w_w0_sat;
                    r_flag <= r_flag | w_ovf_w0;
                end
                STEP_Y: begin
                    r_x    <= w_y_sat;
                    r_flag <= r_flag | w_ovf_y;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end

        if (w_out_load) begin
            r_out_sample <= r_x;
            r_out_sat    <= r_flag;
        end
    end

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `BIQ_ASSERT_SAME(a_step_range, i_clk, i_rst_n, r_state == ST_RUN, r_step >= STEP_PRE && r_step <= STEP_Y, "section step out of range")
    `BIQ_ASSERT_SAME(a_sec_range, i_clk, i_rst_n, r_state == ST_RUN, 32'(r_sec) < TOTAL, "section index beyond cascade")
    `BIQ_ASSERT_SAME(a_out_from_fin, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == ST_FIN, "result appeared outside finish")
    `BIQ_ASSERT_NEXT(a_filter_starts, i_clk, i_rst_n, w_filter_go, r_state != ST_IDLE, "filter transfer did not start a run")

endmodule
